// File: hdl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// gasp_pkg: shared types and constants of the grid path search block
// Request and result records, register indexes, reset values and the
// operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gasp_pkg;

  localparam int GRID_COLS_DEF = 8;
  localparam int GRID_ROWS_DEF = 8;

  localparam logic [7:0] STRAIGHT_RST = 8'd10;
  localparam logic [7:0] DIAG_RST     = 8'd14;

  localparam int          EMIT_MAX = 64;
  localparam logic [13:0] COST_MAX = 14'h3FFF;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic CFG_STRAIGHT = 1'b0;
  localparam logic CFG_DIAG     = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] cell_col;
    logic [2:0] cell_row;
    logic       cell_blocked;
    logic [2:0] goal_col;
    logic [2:0] goal_row;
  } cmd_t;

  typedef struct packed {
    logic        path_found;
    logic [2:0]  path_col;
    logic [2:0]  path_row;
    logic [13:0] path_cost;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search: A* path search on a grid with 8-neighbor moves
// Holds the step cost registers and the output register, and runs cell
// writes and path searches through the search sequencer.
//
//  channel  | direction | beat carries
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | one request: cell write or path search
//  m_axis   | out       | one path cell, or one no-path beat
//  cfg      | in        | one step cost register write
//
// A cell write is done in the idle state. A search sets up, then for each
// expanded cell checks each neighbor, expands and closes the cell, scans the
// open list for the least f, moves the open list entries down and loads the
// next cell. The trace back then follows the parents, and each path beat is
// read from memory and then waits for m_axis_tready.
// Reset clears the cell map at once; there is no clearing pass.
// s_axis_tready is low while a search runs or its result is being sent.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_astar_path_search #(
  parameter int GRID_COLS = gasp_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gasp_pkg::GRID_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cell_col[2:0], cell_row[5:3], cell_blocked[6], goal_col[9:7], goal_row[12:10]
  input  wire logic [15:0] s_axis_tdata,
  // req_type[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // path_col[2:0], path_row[5:3], path_cost[19:6]
  output logic      [23:0] m_axis_tdata,
  // path_found[0]
  output logic      [0:0]  m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]     straight_cost, diagonal_cost;
  gasp_pkg::cmd_t cmd;
  gasp_pkg::res_t res;
  logic           res_valid, res_ready;

  assign cmd.req_type     = s_axis_tuser[0];
  assign cmd.cell_col     = s_axis_tdata[2:0];
  assign cmd.cell_row     = s_axis_tdata[5:3];
  assign cmd.cell_blocked = s_axis_tdata[6];
  assign cmd.goal_col     = s_axis_tdata[9:7];
  assign cmd.goal_row     = s_axis_tdata[12:10];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      straight_cost <= gasp_pkg::STRAIGHT_RST;
      diagonal_cost <= gasp_pkg::DIAG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        gasp_pkg::CFG_STRAIGHT: straight_cost <= cfg_data;
        gasp_pkg::CFG_DIAG:     diagonal_cost <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gasp_core #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (s_axis_tvalid),
    .cmd_ready     (s_axis_tready),
    .cmd           (cmd),
    .straight_cost (straight_cost),
    .diagonal_cost (diagonal_cost),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Output register: the next beat loads while the current one is taken.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {4'd0, res.path_cost, res.path_row, res.path_col};
      m_axis_tuser <= res.path_found;
      m_axis_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gasp_ram.sv
// ----------------------------------------------------------------------------
// gasp_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/gasp_alu.sv
// ----------------------------------------------------------------------------
// gasp_alu: shared arithmetic unit
// Adds two operands or multiplies their low bytes; the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gasp_alu #(
  parameter int WIDTH = 16
) (
  input  wire logic              clk,
  input  gasp_pkg::alu_op_t      op,
  input  wire logic [WIDTH-1:0]  a,
  input  wire logic [WIDTH-1:0]  b,
  output logic      [WIDTH-1:0]  y
);

  logic [15:0] prod;

  assign prod = a[7:0] * b[7:0];

  always_ff @(posedge clk) begin
    unique case (op)
      gasp_pkg::ALU_ADD: y <= WIDTH'(a + b);
      gasp_pkg::ALU_MUL: y <= WIDTH'(prod);
      default:           y <= '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/gasp_core.sv
// ----------------------------------------------------------------------------
// gasp_core: search sequencer
// Holds the cell flags and the cost, parent, open list and path memories,
// and walks one search through expansion, least-f scan, open list removal,
// parent trace and path output, using the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gasp_core #(
  parameter int GRID_COLS = gasp_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gasp_pkg::GRID_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  gasp_pkg::cmd_t   cmd,
  input  wire logic [7:0]  straight_cost,
  input  wire logic [7:0]  diagonal_cost,
  output logic             res_valid,
  input  wire logic        res_ready,
  output gasp_pkg::res_t   res
);

  localparam int CB     = $clog2(GRID_COLS);
  localparam int RB     = $clog2(GRID_ROWS);
  localparam int CW     = CB + RB;
  localparam int DEPTH  = 2 ** CW;
  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int GW     = $clog2(NCELLS * 255 + 1);
  localparam int FW     = $clog2(NCELLS * 255 + 130 * 255 + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_H, S_INIT_W, S_EXPAND,
    S_NB_POS, S_NB_CHK1, S_NB_CHK2, S_NB_CHK3, S_NB_H, S_NB_F, S_NB_UPD, S_NB_NEXT,
    S_CLOSE, S_SCAN, S_SH_RD, S_SH_WR, S_SEL, S_SEL2,
    S_TR_PUSH, S_TR_RD, S_EM_RD1, S_EM_RD2, S_EM_RD3, S_EM_OUT, S_NOPATH
  } state_t;

  state_t state;

  logic [DEPTH-1:0] blocked_map, open_mark, closed_mark;

  logic [CB-1:0] start_c, goal_c, cur_c, nb_c, nb_c_calc, in_c, in_gc;
  logic [RB-1:0] start_r, goal_r, cur_r, nb_r, nb_r_calc, in_r, in_gr;
  logic [CB+2:0] in_c_w, in_gc_w;
  logic [RB+2:0] in_r_w, in_gr_w;
  logic          in_range, goal_in_range;
  logic [1:0]    dr, dc;
  logic          pos_ok, nb_last, diag_step;
  logic [CW-1:0] nb, cur, start_cell, goal_cell, blk_addr;
  logic          blk_bit;

  logic [GW-1:0] g_cur, g_new, g_old, g_emit;
  logic [CW:0]   open_count, scan_idx, shift_idx, path_n;
  logic [CW+1:0] guard;
  logic [CW+8:0] n1_w, stk_ptr_w;

  logic          p1_v, p2_v;
  logic [CW-1:0] p1_idx, p2_idx, p2_cell, best_idx, best_cell;
  logic [FW-1:0] best_f;
  logic [CW-1:0] trace_k, emit_cell;
  logic [6:0]    emit_i, emit_cnt;
  logic          emit_last;
  logic [CB+2:0] out_c_w;
  logic [RB+2:0] out_r_w;
  logic [GW+13:0] g_emit_w;

  gasp_pkg::alu_op_t alu_op;
  logic [FW-1:0]     alu_a, alu_b, alu_y;

  logic          g_we, f_we, par_we, ord_we, stk_we;
  logic [CW-1:0] g_raddr, ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [CW-1:0] par_rdata, stk_raddr, stk_rdata;
  logic [GW-1:0] g_rdata;
  logic [FW-1:0] f_rdata;

  function automatic logic [7:0] manh(input logic [CB-1:0] ac, input logic [CB-1:0] bc,
                                      input logic [RB-1:0] ar, input logic [RB-1:0] br);
    logic [7:0] dcol, drow;
    dcol = (ac > bc) ? 8'(ac - bc) : 8'(bc - ac);
    drow = (ar > br) ? 8'(ar - br) : 8'(br - ar);
    return dcol + drow;
  endfunction

  // Request coordinates, range checked before narrowing to the grid width.
  assign in_c_w   = {{CB{1'b0}}, cmd.cell_col};
  assign in_r_w   = {{RB{1'b0}}, cmd.cell_row};
  assign in_gc_w  = {{CB{1'b0}}, cmd.goal_col};
  assign in_gr_w  = {{RB{1'b0}}, cmd.goal_row};
  assign in_c     = in_c_w[CB-1:0];
  assign in_r     = in_r_w[RB-1:0];
  assign in_gc    = in_gc_w[CB-1:0];
  assign in_gr    = in_gr_w[RB-1:0];
  assign in_range = (in_c_w < (CB+3)'(GRID_COLS)) && (in_r_w < (RB+3)'(GRID_ROWS));
  assign goal_in_range = (in_gc_w < (CB+3)'(GRID_COLS)) && (in_gr_w < (RB+3)'(GRID_ROWS));

  assign cur        = {cur_c, cur_r};
  assign nb         = {nb_c, nb_r};
  assign start_cell = {start_c, start_r};
  assign goal_cell  = {goal_c, goal_r};

  // Neighbor window: dr and dc step 0..2 for offsets -1..+1, rows outermost.
  assign nb_c_calc = (dc == 2'd0) ? cur_c - CB'(1) : (dc == 2'd2) ? cur_c + CB'(1) : cur_c;
  assign nb_r_calc = (dr == 2'd0) ? cur_r - RB'(1) : (dr == 2'd2) ? cur_r + RB'(1) : cur_r;
  assign pos_ok = !(dc == 2'd0 && cur_c == '0) &&
                  !(dc == 2'd2 && cur_c == CB'(GRID_COLS - 1)) &&
                  !(dr == 2'd0 && cur_r == '0) &&
                  !(dr == 2'd2 && cur_r == RB'(GRID_ROWS - 1)) &&
                  !(dr == 2'd1 && dc == 2'd1);
  assign nb_last   = (dr == 2'd2) && (dc == 2'd2);
  assign diag_step = (dr != 2'd1) && (dc != 2'd1);

  always_comb begin
    unique case (state)
      S_NB_CHK2: blk_addr = {nb_c, cur_r};
      S_NB_CHK3: blk_addr = {cur_c, nb_r};
      default:   blk_addr = nb;
    endcase
  end
  assign blk_bit = blocked_map[blk_addr];

  // Shared unit operand selection.
  always_comb begin
    alu_op = gasp_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      S_INIT_H: begin
        alu_op = gasp_pkg::ALU_MUL;
        alu_a  = FW'(manh(start_c, goal_c, start_r, goal_r));
        alu_b  = FW'(straight_cost);
      end
      S_NB_CHK3: begin
        alu_a = FW'(g_cur);
        alu_b = FW'(diag_step ? diagonal_cost : straight_cost);
      end
      S_NB_H: begin
        alu_op = gasp_pkg::ALU_MUL;
        alu_a  = FW'(manh(nb_c, goal_c, nb_r, goal_r));
        alu_b  = FW'(straight_cost);
      end
      S_NB_F: begin
        alu_a = FW'(g_new);
        alu_b = alu_y;
      end
      default: begin
      end
    endcase
  end

  gasp_alu #(.WIDTH(FW)) u_alu (
    .clk (clk),
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  // Memory write enables and read addresses.
  always_comb begin
    g_we      = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = open_count[CW-1:0];
    ord_wdata = nb;
    stk_we    = 1'b0;
    unique case (state)
      S_INIT_W: g_we = 1'b1;
      S_NB_UPD: begin
        if (open_mark[nb]) begin
          g_we = (g_old > g_new);
        end else if (open_count < (CW+1)'(NCELLS)) begin
          g_we   = 1'b1;
          ord_we = 1'b1;
        end
      end
      S_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = shift_idx[CW-1:0];
        ord_wdata = ord_rdata;
      end
      S_TR_PUSH: stk_we = 1'b1;
      default: begin
      end
    endcase
  end
  assign f_we   = g_we;
  assign par_we = g_we;

  always_comb begin
    unique case (state)
      S_SEL:    g_raddr = cur;
      S_EM_RD2: g_raddr = stk_rdata;
      default:  g_raddr = nb;
    endcase
  end

  assign ord_raddr = (state == S_SCAN) ? scan_idx[CW-1:0] : CW'(shift_idx + 1'b1);
  assign stk_ptr_w = (CW+9)'(path_n) - (CW+9)'(1) - (CW+9)'(emit_i);
  assign stk_raddr = stk_ptr_w[CW-1:0];

  gasp_ram #(.WIDTH(GW), .DEPTH(DEPTH)) u_g_ram (
    .clk (clk), .we (g_we), .waddr ((state == S_INIT_W) ? start_cell : nb),
    .wdata ((state == S_INIT_W) ? '0 : g_new), .raddr (g_raddr), .rdata (g_rdata)
  );

  gasp_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_f_ram (
    .clk (clk), .we (f_we), .waddr ((state == S_INIT_W) ? start_cell : nb),
    .wdata (alu_y), .raddr (ord_rdata), .rdata (f_rdata)
  );

  gasp_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_par_ram (
    .clk (clk), .we (par_we), .waddr ((state == S_INIT_W) ? start_cell : nb),
    .wdata (cur), .raddr (trace_k), .rdata (par_rdata)
  );

  gasp_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ord_ram (
    .clk (clk), .we (ord_we), .waddr (ord_waddr),
    .wdata (ord_wdata), .raddr (ord_raddr), .rdata (ord_rdata)
  );

  gasp_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_stk_ram (
    .clk (clk), .we (stk_we), .waddr (path_n[CW-1:0]),
    .wdata (trace_k), .raddr (stk_raddr), .rdata (stk_rdata)
  );

  assign n1_w      = (CW+9)'(path_n) + (CW+9)'(1);
  assign emit_last = ((emit_i + 7'd1) == emit_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      blocked_map <= '0;
      open_mark   <= '0;
      closed_mark <= '0;
      open_count  <= '0;
      p1_v        <= 1'b0;
      p2_v        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.req_type == gasp_pkg::REQ_WRITE) begin
              if (in_range) begin
                blocked_map[{in_c, in_r}] <= cmd.cell_blocked;
              end
            end else if (!in_range || !goal_in_range) begin
              state <= S_NOPATH;
            end else begin
              start_c     <= in_c;
              start_r     <= in_r;
              cur_c       <= in_c;
              cur_r       <= in_r;
              goal_c      <= in_gc;
              goal_r      <= in_gr;
              open_mark   <= '0;
              closed_mark <= '0;
              open_count  <= '0;
              g_cur       <= '0;
              guard       <= '0;
              state       <= S_INIT_H;
            end
          end
        end
        S_INIT_H: state <= S_INIT_W;
        S_INIT_W: state <= S_EXPAND;
        S_EXPAND: begin
          if (cur == goal_cell) begin
            path_n  <= '0;
            trace_k <= cur;
            state   <= S_TR_PUSH;
          end else if (guard == (CW+2)'(NCELLS)) begin
            state <= S_NOPATH;
          end else begin
            guard <= guard + 1'b1;
            dr    <= 2'd0;
            dc    <= 2'd0;
            state <= S_NB_POS;
          end
        end
        S_NB_POS: begin
          nb_c  <= nb_c_calc;
          nb_r  <= nb_r_calc;
          state <= pos_ok ? S_NB_CHK1 : S_NB_NEXT;
        end
        S_NB_CHK1: state <= (blk_bit || closed_mark[nb]) ? S_NB_NEXT : S_NB_CHK2;
        S_NB_CHK2: state <= blk_bit ? S_NB_NEXT : S_NB_CHK3;
        S_NB_CHK3: state <= blk_bit ? S_NB_NEXT : S_NB_H;
        S_NB_H: begin
          g_new <= alu_y[GW-1:0];
          g_old <= g_rdata;
          state <= S_NB_F;
        end
        S_NB_F: state <= S_NB_UPD;
        S_NB_UPD: begin
          if (!open_mark[nb] && open_count < (CW+1)'(NCELLS)) begin
            open_mark[nb] <= 1'b1;
            open_count    <= open_count + 1'b1;
          end
          state <= S_NB_NEXT;
        end
        S_NB_NEXT: begin
          if (nb_last) begin
            state <= S_CLOSE;
          end else begin
            if (dc == 2'd2) begin
              dc <= 2'd0;
              dr <= dr + 2'd1;
            end else begin
              dc <= dc + 2'd1;
            end
            state <= S_NB_POS;
          end
        end
        S_CLOSE: begin
          closed_mark[cur] <= 1'b1;
          open_mark[cur]   <= 1'b0;
          scan_idx         <= '0;
          p1_v             <= 1'b0;
          p2_v             <= 1'b0;
          state            <= (open_count == '0) ? S_NOPATH : S_SCAN;
        end
        S_SCAN: begin
          // Three-deep walk: open list slot, then its f, then the compare.
          p1_v    <= (scan_idx < open_count);
          p1_idx  <= scan_idx[CW-1:0];
          if (scan_idx < open_count) begin
            scan_idx <= scan_idx + 1'b1;
          end
          p2_v    <= p1_v;
          p2_idx  <= p1_idx;
          p2_cell <= ord_rdata;
          if (p2_v && (p2_idx == '0 || f_rdata < best_f)) begin
            best_f    <= f_rdata;
            best_idx  <= p2_idx;
            best_cell <= p2_cell;
          end
          if (scan_idx == open_count && !p1_v && !p2_v) begin
            shift_idx <= {1'b0, best_idx};
            state     <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if ((shift_idx + 1'b1) < open_count) begin
            state <= S_SH_WR;
          end else begin
            open_count <= open_count - 1'b1;
            cur_c      <= best_cell[CW-1:RB];
            cur_r      <= best_cell[RB-1:0];
            state      <= S_SEL;
          end
        end
        S_SH_WR: begin
          shift_idx <= shift_idx + 1'b1;
          state     <= S_SH_RD;
        end
        S_SEL:  state <= S_SEL2;
        S_SEL2: begin
          g_cur <= g_rdata;
          state <= S_EXPAND;
        end
        S_TR_PUSH: begin
          path_n <= path_n + 1'b1;
          if (trace_k == start_cell || n1_w >= (CW+9)'(NCELLS)) begin
            emit_cnt <= (n1_w > (CW+9)'(gasp_pkg::EMIT_MAX)) ?
                        7'(gasp_pkg::EMIT_MAX) : n1_w[6:0];
            emit_i   <= '0;
            state    <= S_EM_RD1;
          end else begin
            state <= S_TR_RD;
          end
        end
        S_TR_RD: begin
          trace_k <= par_rdata;
          state   <= S_TR_PUSH;
        end
        S_EM_RD1: state <= S_EM_RD2;
        S_EM_RD2: begin
          emit_cell <= stk_rdata;
          state     <= S_EM_RD3;
        end
        S_EM_RD3: begin
          g_emit <= (emit_i == '0) ? '0 : g_rdata;
          state  <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (res_ready) begin
            emit_i <= emit_i + 7'd1;
            state  <= emit_last ? S_IDLE : S_EM_RD1;
          end
        end
        S_NOPATH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_EM_OUT) || (state == S_NOPATH);

  assign out_c_w  = {3'b000, emit_cell[CW-1:RB]};
  assign out_r_w  = {3'b000, emit_cell[RB-1:0]};
  assign g_emit_w = {14'd0, g_emit};

  always_comb begin
    if (state == S_NOPATH) begin
      res = '{path_found: 1'b0, path_col: 3'd0, path_row: 3'd0,
              path_cost: 14'd0, last: 1'b1};
    end else begin
      res.path_found = 1'b1;
      res.path_col   = out_c_w[2:0];
      res.path_row   = out_r_w[2:0];
      res.path_cost  = (g_emit_w > (GW+14)'(gasp_pkg::COST_MAX)) ?
                       gasp_pkg::COST_MAX : g_emit_w[13:0];
      res.last       = emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= (CW+1)'(NCELLS))
    else $error("open list count beyond grid size");

  a_nopath_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.path_found) |-> res.last)
    else $error("no-path beat without last");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.req_type == gasp_pkg::REQ_WRITE) |=> cmd_ready)
    else $error("cell write left the sequencer busy");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_OUT) |-> (emit_i < emit_cnt && emit_cnt <= 7'(gasp_pkg::EMIT_MAX)))
    else $error("path output index out of range");
`endif

endmodule

`default_nettype wire

// File: dv/tb_grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search: self-checking bench for the grid path search
// Drives cell writes and path searches with random gaps, predicts each path
// with a behavioral A* search of its own, and compares every result beat in
// order. Step costs are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class path_scoreboard;
  bit          blocked [64];
  logic [7:0]  straight_cost;
  logic [7:0]  diagonal_cost;
  gasp_pkg::res_t pending [$];
  int          errors;

  function new();
    foreach (blocked[i]) blocked[i] = 0;
    straight_cost = gasp_pkg::STRAIGHT_RST;
    diagonal_cost = gasp_pkg::DIAG_RST;
    errors = 0;
  endfunction

  function int unsigned heur(int c, int r, int gc, int gr);
    int dc;
    int dr;
    dc = c > gc ? c - gc : gc - c;
    dr = r > gr ? r - gr : gr - r;
    return (dc + dr) * straight_cost;
  endfunction

  function void push_none();
    gasp_pkg::res_t e;
    e = '0;
    e.last = 1'b1;
    pending.push_back(e);
  endfunction

  // Predicts the beats of one search and queues them.
  function void predict_path(int sc, int sr, int gc, int gr);
    bit          open_m [64];
    bit          closed_m [64];
    int unsigned g_of [64];
    int unsigned f_of [64];
    int          par [64];
    int          order [$];
    int          trail [$];
    int          cur, goal, cc, cr, guard, bi, nb, k;
    int unsigned g, f, best;
    gasp_pkg::res_t e;
    foreach (open_m[i]) begin
      open_m[i] = 0;
      closed_m[i] = 0;
    end
    cc = sc;
    cr = sr;
    cur = sc * 8 + sr;
    goal = gc * 8 + gr;
    g_of[cur] = 0;
    f_of[cur] = heur(sc, sr, gc, gr);
    par[cur] = cur;
    guard = 0;
    while (cur != goal) begin
      guard++;
      if (guard > 64) begin
        push_none();
        return;
      end
      for (int r = (cr > 0 ? cr - 1 : 0); r < (cr + 2 < 8 ? cr + 2 : 8); r++) begin
        for (int c = (cc > 0 ? cc - 1 : 0); c < (cc + 2 < 8 ? cc + 2 : 8); c++) begin
          nb = c * 8 + r;
          if (nb == cur || blocked[nb] || closed_m[nb]) continue;
          if (blocked[c * 8 + cr] || blocked[cc * 8 + r]) continue;
          g = g_of[cur] + ((r != cr && c != cc) ? diagonal_cost : straight_cost);
          f = g + heur(c, r, gc, gr);
          if (open_m[nb]) begin
            if (g_of[nb] > g) begin
              g_of[nb] = g;
              f_of[nb] = f;
              par[nb] = cur;
            end
          end else if (order.size() < 64) begin
            g_of[nb] = g;
            f_of[nb] = f;
            par[nb] = cur;
            open_m[nb] = 1;
            order.push_back(nb);
          end
        end
      end
      closed_m[cur] = 1;
      open_m[cur] = 0;
      if (order.size() == 0) begin
        push_none();
        return;
      end
      bi = 0;
      best = f_of[order[0]];
      for (int i = 1; i < order.size(); i++) begin
        if (f_of[order[i]] < best) begin
          best = f_of[order[i]];
          bi = i;
        end
      end
      cur = order[bi];
      order.delete(bi);
      cc = cur / 8;
      cr = cur % 8;
    end
    k = cur;
    trail.push_front(k);
    while (k != sc * 8 + sr && trail.size() < 64) begin
      k = par[k];
      trail.push_front(k);
    end
    foreach (trail[i]) begin
      e.path_found = 1'b1;
      e.path_col = 3'(trail[i] / 8);
      e.path_row = 3'(trail[i] % 8);
      e.path_cost = (i == 0) ? 14'd0 :
                    (g_of[trail[i]] > 16383 ? gasp_pkg::COST_MAX : 14'(g_of[trail[i]]));
      e.last = (i == trail.size() - 1);
      pending.push_back(e);
    end
  endfunction

  function void note_request(gasp_pkg::cmd_t cmd);
    if (cmd.req_type == gasp_pkg::REQ_WRITE)
      blocked[cmd.cell_col * 8 + cmd.cell_row] = cmd.cell_blocked;
    else
      predict_path(cmd.cell_col, cmd.cell_row, cmd.goal_col, cmd.goal_row);
  endfunction

  function void note_config(logic idx, logic [7:0] val);
    if (idx == gasp_pkg::CFG_STRAIGHT) straight_cost = val;
    else diagonal_cost = val;
  endfunction

  function void report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endfunction

  function void check_beat(gasp_pkg::res_t got);
    gasp_pkg::res_t exp;
    if (pending.size() == 0) begin
      report($sformatf("unexpected beat %p", got));
      return;
    end
    exp = pending.pop_front();
    if (got.path_found !== exp.path_found)
      report($sformatf("path_found %0b, want %0b", got.path_found, exp.path_found));
    if (got.path_col !== exp.path_col)
      report($sformatf("path_col %0d, want %0d", got.path_col, exp.path_col));
    if (got.path_row !== exp.path_row)
      report($sformatf("path_row %0d, want %0d", got.path_row, exp.path_row));
    if (got.path_cost !== exp.path_cost)
      report($sformatf("path_cost %0d, want %0d", got.path_cost, exp.path_cost));
    if (got.last !== exp.last)
      report($sformatf("last %0b, want %0b", got.last, exp.last));
  endfunction
endclass

module tb_grid_astar_path_search;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  path_scoreboard sb;
  bit          stall_enable;
  int          stall_left;

  grid_astar_path_search u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The beat stays up after acceptance until the next gap or the next beat,
  // so back-to-back beats need only one update of the valid line.
  task automatic send_request(gasp_pkg::cmd_t cmd);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd.req_type;
    s_axis_tdata  <= {3'b0, cmd.goal_row, cmd.goal_col, cmd.cell_blocked,
                      cmd.cell_row, cmd.cell_col};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(cmd);
  endtask

  task automatic write_cell(int c, int r, bit blk);
    gasp_pkg::cmd_t cmd;
    cmd = '0;
    cmd.req_type = gasp_pkg::REQ_WRITE;
    cmd.cell_col = 3'(c);
    cmd.cell_row = 3'(r);
    cmd.cell_blocked = blk;
    send_request(cmd);
  endtask

  task automatic find_path(int sc, int sr, int gc, int gr);
    gasp_pkg::cmd_t cmd;
    cmd = '0;
    cmd.req_type = gasp_pkg::REQ_SEARCH;
    cmd.cell_col = 3'(sc);
    cmd.cell_row = 3'(sr);
    cmd.goal_col = 3'(gc);
    cmd.goal_row = 3'(gr);
    cmd.cell_blocked = 1'($urandom_range(0, 1));
    send_request(cmd);
  endtask

  task automatic write_cost(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Result side: random backpressure while stalls are enabled, checked at every accepted beat.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_beat({m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tdata[5:3],
                     m_axis_tdata[19:6], m_axis_tlast});
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (!stall_enable) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      m_axis_tready <= 1'b0;
      stall_left    <= gap_len();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int kind;
    sb = new();
    rst = 1'b1;
    stall_enable = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: trivial, corner-to-corner, walls, blocked start and goal.
    find_path(3, 3, 3, 3);
    find_path(0, 0, 7, 7);
    find_path(7, 7, 0, 0);
    find_path(7, 0, 0, 7);
    write_cell(1, 0, 1);
    write_cell(0, 1, 1);
    find_path(0, 0, 5, 5);
    find_path(0, 0, 0, 0);
    write_cell(1, 0, 0);
    find_path(0, 0, 4, 0);
    write_cell(4, 0, 1);
    find_path(0, 0, 4, 0);
    find_path(4, 0, 0, 0);
    find_path(4, 0, 4, 0);
    for (int r = 0; r < 8; r++) write_cell(5, r, 1);
    find_path(0, 3, 7, 3);
    write_cell(5, 6, 0);
    find_path(0, 3, 7, 3);
    drain();

    write_cost(gasp_pkg::CFG_STRAIGHT, 8'd255);
    write_cost(gasp_pkg::CFG_DIAG, 8'd1);
    find_path(0, 0, 7, 7);
    find_path(6, 7, 1, 2);
    drain();
    write_cost(gasp_pkg::CFG_STRAIGHT, 8'd1);
    write_cost(gasp_pkg::CFG_DIAG, 8'd255);
    find_path(0, 0, 7, 7);
    drain();
    for (int i = 0; i < 64; i++) begin
      if (sb.blocked[i]) write_cell(i / 8, i % 8, 0);
    end

    // Random phases with different cost settings and stalls switched on in all but the third phase.
    stall_enable = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_cost(gasp_pkg::CFG_STRAIGHT, ph == 0 ? 8'd10 : 8'($urandom_range(1, 255)));
      write_cost(gasp_pkg::CFG_DIAG, ph == 0 ? 8'd14 : 8'($urandom_range(1, 255)));
      stall_enable = (ph != 2);
      for (int n = 0; n < 22; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 55)
          write_cell($urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 99) < 35);
        else
          find_path($urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7));
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: sim.f
hdl/gasp_pkg.sv
hdl/gasp_ram.sv
hdl/gasp_alu.sv
hdl/gasp_core.sv
hdl/grid_astar_path_search.sv
dv/tb_grid_astar_path_search.sv
